// ===== rtl/core/mcpe_pkg.sv =====
// Package for the mesh command packet encryptor: payload types, register
// indexes and AES helper functions. No dependencies.
package mcpe_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;
  localparam int QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_LO  = 3'd0,
    REG_KEY_HI  = 3'd1,
    REG_LINK    = 3'd2,
    REG_VENDOR  = 3'd3,
    REG_COUNT   = 3'd4,
    REG_READY   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0]  payload_count;
    logic [15:0] payload_hi;
    logic [63:0] payload_lo;
    logic [7:0]  command_op;
    logic [15:0] target_addr;
  } cmd_in_t;

  typedef struct packed {
    logic [31:0] packet_bytes_16_19;
    logic [63:0] packet_bytes_8_15;
    logic [63:0] packet_bytes_0_7;
    logic        accepted;
  } pkt_out_t;

  // Classified job handed from the front to the back.
  typedef struct packed {
    logic         accepted;
    logic [127:0] key;
    logic [127:0] nonce;
    logic [127:0] iv;
    logic [119:0] plain;   // packet bytes 5..19, byte 5 in bits 7:0
    logic [15:0]  counter;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Blocks hold AES byte i in bits 8i+7:8i.
  function automatic logic [127:0] rev16(input logic [127:0] a);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[8*i +: 8] = a[8*(15-i) +: 8];
    return r;
  endfunction

  // One AES round; last drops MixColumns.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        t[8*(4*c+i) +: 8] = sbox(s[8*(4*((c+i)%4)+i) +: 8]);
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[8*(4*c) +: 8]; a1 = t[8*(4*c+1) +: 8];
        a2 = t[8*(4*c+2) +: 8]; a3 = t[8*(4*c+3) +: 8];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[8*(4*c) +: 8]   = a0 ^ al ^ xt(a0 ^ a1);
        t[8*(4*c+1) +: 8] = a1 ^ al ^ xt(a1 ^ a2);
        t[8*(4*c+2) +: 8] = a2 ^ al ^ xt(a2 ^ a3);
        t[8*(4*c+3) +: 8] = a3 ^ al ^ xt(a3 ^ a0);
      end
    end
    return t ^ rk;
  endfunction

  function automatic logic [127:0] next_rk(input logic [127:0] k, input logic [7:0] rcon);
    logic [127:0] r;
    logic [31:0] w;
    w = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]), sbox(k[111:104]) ^ rcon};
    r[31:0]   = k[31:0] ^ w;
    r[63:32]  = k[63:32] ^ r[31:0];
    r[95:64]  = k[95:64] ^ r[63:32];
    r[127:96] = k[127:96] ^ r[95:64];
    return r;
  endfunction

endpackage

// ===== rtl/core/mesh_command_packet_encrypt_unit.sv =====
// Channel   | Ports                         | Meaning
// input     | in_push, in_full, in_data     | one command item
// result    | out_pop, out_empty, out_data  | one packet item
// config    | cfg_we, cfg_idx, cfg_data     | register write
// An encrypted item takes three AES passes of ten rounds on one shared
// round unit in the back end; refused items skip the passes. A two-entry
// job queue takes new items while the round unit works, and the output
// register holds one finished packet.
// Reset is synchronous, active low, and clears the counter to 1.
// Depends on mcpe_pkg and the front, queue and back modules.
module mesh_command_packet_encrypt_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  mcpe_pkg::cmd_in_t             in_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output mcpe_pkg::pkt_out_t            out_data,
  input  logic                          cfg_we,
  input  logic [mcpe_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [mcpe_pkg::CfgDataW-1:0] cfg_data
);
  import mcpe_pkg::*;

  job_t fjob, qjob;
  logic take, q_empty, q_rd, o_vld;

  assign take = in_push && !in_full;
  assign out_empty = !o_vld;

  mcpe_front u_front (.clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
                      .take, .cmd(in_data), .job(fjob));
  mcpe_queue u_queue (.clk, .rst_n, .wr(in_push), .wdata(fjob), .full(in_full),
                      .rd(q_rd), .empty(q_empty), .rdata(qjob));
  mcpe_back u_back (.clk, .rst_n, .job_vld(!q_empty), .job(qjob), .job_take(q_rd),
                    .out_vld(o_vld), .out_pkt(out_data), .out_take(out_pop));
endmodule

// ===== rtl/core/mcpe_front.sv =====
// Front end: holds the configuration registers and the packet counter,
// and turns each command into a job for the AES back end. Uses mcpe_pkg.
module mcpe_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mcpe_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [mcpe_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          take,
  input  mcpe_pkg::cmd_in_t             cmd,
  output mcpe_pkg::job_t                job
);
  import mcpe_pkg::*;

  logic [63:0] key_lo_r, key_hi_r;
  logic [31:0] link_r;
  logic [15:0] vendor_r, ctr_r, ctr_nxt;
  logic        ready_r;
  logic [3:0]  n;
  logic [79:0] raw;
  logic [79:0] pay;
  logic [127:0] key_b;

  always_comb begin
    n = (cmd.payload_count > 4'd10) ? 4'd10 : cmd.payload_count;
    raw = {cmd.payload_hi, cmd.payload_lo};
    for (int i = 0; i < 10; i++) begin
      pay[8*i +: 8] = (4'(i) < n) ? raw[8*i +: 8] : 8'h00;
    end
    ctr_nxt = (ctr_r == 16'hffff) ? 16'd1 : ctr_r + 16'd1;
    key_b = {key_hi_r, key_lo_r};
    job.accepted = ready_r;
    job.counter  = ctr_r;
    job.key      = rev16(key_b);
    job.plain    = {pay, vendor_r, cmd.command_op, cmd.target_addr};
    // Nonce and IV reversed here so the back end runs plain AES.
    job.nonce = rev16({56'd0, 8'h0f, 8'h00, ctr_r, 8'h01, link_r});
    job.iv    = rev16({56'd0, 8'h00, ctr_r, 8'h01, link_r, 8'h00});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0; key_hi_r <= '0; link_r <= '0; vendor_r <= '0;
      ctr_r <= 16'd1; ready_r <= 1'b0;
    end else begin
      if (take && ready_r) ctr_r <= ctr_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_KEY_LO: key_lo_r <= cfg_data;
          REG_KEY_HI: key_hi_r <= cfg_data;
          REG_LINK:   link_r <= cfg_data[31:0];
          REG_VENDOR: vendor_r <= cfg_data[15:0];
          REG_COUNT:  ctr_r <= (cfg_data[15:0] == 16'd0) ? 16'd1 : cfg_data[15:0];
          REG_READY:  ready_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== rtl/core/mcpe_queue.sv =====
// Two-entry queue of jobs between front and back end. Uses mcpe_pkg.
module mcpe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  mcpe_pkg::job_t wdata,
  output logic           full,
  input  logic           rd,
  output logic           empty,
  output mcpe_pkg::job_t rdata
);
  import mcpe_pkg::*;

  job_t mem [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wp_r, rp_r;
  logic [$clog2(QueueDepth):0] cnt_r;

  assign full  = (cnt_r == ($clog2(QueueDepth)+1)'(QueueDepth));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr && !full) wp_r <= wp_r + 1'b1;
      if (rd && !empty) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + ((wr && !full) ? 1'b1 : 1'b0) - ((rd && !empty) ? 1'b1 : 1'b0);
    end
  end
endmodule

// ===== rtl/core/mcpe_back.sv =====
// Back end: one iterative AES-128 round unit run three times per accepted
// packet (nonce, MIC, counter keystream), then an output register. Uses mcpe_pkg.
module mcpe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_vld,
  input  mcpe_pkg::job_t    job,
  output logic              job_take,
  output logic              out_vld,
  output mcpe_pkg::pkt_out_t out_pkt,
  input  logic              out_take
);
  import mcpe_pkg::*;

  typedef enum logic [1:0] {IDLE, RUN, DONE} st_t;
  typedef enum logic [1:0] {P_NONCE, P_MIC, P_CTR} pass_t;

  st_t          st_r;
  pass_t        pass_r;
  logic [3:0]   rnd_r;
  logic [127:0] s_r, rk_r, st_nxt, rk_nxt, res;
  logic [7:0]   rcon_r;
  job_t         job_r;
  logic [15:0]  mic_r;
  logic         full_r;
  pkt_out_t     pkt_r;
  pkt_out_t     out_r;
  logic [119:0] enc;

  assign job_take = (st_r == IDLE) && job_vld;
  assign out_vld  = full_r;
  assign out_pkt  = out_r;

  always_comb begin
    rk_nxt = next_rk(rk_r, rcon_r);
    st_nxt = aes_round(s_r, rk_nxt, rnd_r == 4'd10);
    res    = rev16(st_nxt);
    enc    = job_r.plain ^ res[119:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= IDLE; full_r <= 1'b0; pass_r <= P_NONCE; rnd_r <= 4'd1;
    end else begin
      if (out_take && full_r) full_r <= 1'b0;
      case (st_r)
        IDLE: if (job_vld) begin
          job_r <= job;
          if (job.accepted) begin
            st_r <= RUN; pass_r <= P_NONCE; rnd_r <= 4'd1; rcon_r <= 8'h01;
            rk_r <= job.key; s_r <= job.nonce ^ job.key;
          end else begin
            pkt_r <= '0; st_r <= DONE;
          end
        end
        RUN: begin
          if (rnd_r == 4'd10) begin
            rnd_r <= 4'd1; rcon_r <= 8'h01; rk_r <= job_r.key;
            case (pass_r)
              P_NONCE: begin
                pass_r <= P_MIC;
                // The last byte of the first block passes through unchanged.
                s_r <= rev16({res[127:120], enc}) ^ job_r.key;
              end
              P_MIC: begin
                pass_r <= P_CTR; mic_r <= res[15:0];
                s_r <= job_r.iv ^ job_r.key;
              end
              default: begin
                pkt_r.accepted <= 1'b1;
                pkt_r.packet_bytes_0_7 <= {enc[23:0], mic_r, 8'h00, job_r.counter};
                pkt_r.packet_bytes_8_15 <= enc[87:24];
                pkt_r.packet_bytes_16_19 <= enc[119:88];
                st_r <= DONE;
              end
            endcase
          end else begin
            rnd_r <= rnd_r + 4'd1; rcon_r <= xt(rcon_r);
            rk_r <= rk_nxt; s_r <= st_nxt;
          end
        end
        DONE: if (!full_r || out_take) begin
          full_r <= 1'b1; out_r <= pkt_r; st_r <= IDLE;
        end
        default: st_r <= IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/mcpe_checker.sv =====
// Port-level checks for the packet encryptor, bound to the top level.
// Uses mcpe_pkg.
module mcpe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input mcpe_pkg::pkt_out_t out_data
);
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("not empty after reset");
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.accepted) |-> out_data.packet_bytes_0_7 == 64'd0)
    else $error("refused item carries data");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty && $stable(out_data))
    else $error("waiting item changed");
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty) |-> out_data.packet_bytes_0_7[23:16] == 8'd0)
    else $error("packet byte 2 not zero");
endmodule

bind mesh_command_packet_encrypt_unit mcpe_checker u_mcpe_checker (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_data);

// ===== verif/mesh_command_packet_encrypt_checker.sv =====
// Checker for the mesh command packet encryptor: follows the register port,
// predicts each packet from every accepted command and compares it with the
// packets popped. Depends on mcpe_pkg.
`timescale 1ns / 100ps
module mesh_command_packet_encrypt_checker
  import mcpe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  cmd_in_t             in_data,
  input  logic                out_empty,
  input  logic                out_pop,
  input  pkt_out_t            out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  mismatches,
  output int                  pending
);

  logic [7:0]   sub_tab [256];
  logic [63:0]  key_lo, key_hi;
  logic [31:0]  link_prefix;
  logic [15:0]  vendor_reg;
  logic         ready;
  logic [15:0]  pkt_count;
  pkt_out_t     packet_q [$];

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // The substitution table is derived from the field inverse and the affine map.
  initial begin
    logic [7:0] inv, s;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++)
        if (gf_mul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tab[a] = s;
    end
  end

  // Plain AES-128; byte i of every block sits in bits 8i+7:8i.
  function automatic logic [127:0] aes_block(input logic [127:0] key, input logic [127:0] pt);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w0, w1, w2, w3, tmp, rc, a0, a1, a2, a3, al;
    logic [127:0] r;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) rk[i] = key[8*i +: 8];
    for (int i = 16; i < 176; i += 4) begin
      w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
      if ((i % 16) == 0) begin
        tmp = w0;
        w0 = sub_tab[w1] ^ rc;
        w1 = sub_tab[w2];
        w2 = sub_tab[w3];
        w3 = sub_tab[tmp];
        rc = gf_mul(rc, 8'h02);
      end
      rk[i] = rk[i-16] ^ w0;
      rk[i+1] = rk[i-15] ^ w1;
      rk[i+2] = rk[i-14] ^ w2;
      rk[i+3] = rk[i-13] ^ w3;
    end
    for (int i = 0; i < 16; i++) s[i] = pt[8*i +: 8] ^ rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++)
          t[4*c+i] = sub_tab[s[4*((c+i)%4)+i]];
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ gf_mul(a0 ^ a1, 8'h02);
          t[4*c+1] = a1 ^ al ^ gf_mul(a1 ^ a2, 8'h02);
          t[4*c+2] = a2 ^ al ^ gf_mul(a2 ^ a3, 8'h02);
          t[4*c+3] = a3 ^ al ^ gf_mul(a3 ^ a0, 8'h02);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*rnd+i];
    end
    for (int i = 0; i < 16; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  function automatic logic [127:0] byte_swap(input logic [127:0] a);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[8*i +: 8] = a[8*(15-i) +: 8];
    return r;
  endfunction

  // The link layer feeds key, block and result to AES in reversed byte order.
  function automatic logic [127:0] link_cipher(input logic [127:0] pt);
    return byte_swap(aes_block(byte_swap({key_hi, key_lo}), byte_swap(pt)));
  endfunction

  function automatic pkt_out_t encrypt_command(input cmd_in_t c);
    pkt_out_t     o;
    logic [79:0]  body;
    logic [119:0] plain, cipher;
    logic [127:0] nonce, iv, tag, ks;
    logic [159:0] pk;
    int           n;
    o = '0;
    if (!ready) return o;
    n = (c.payload_count > 10) ? 10 : c.payload_count;
    body = {c.payload_hi, c.payload_lo};
    for (int i = n; i < 10; i++) body[8*i +: 8] = 8'h00;
    plain = {body, vendor_reg, c.command_op, c.target_addr};
    nonce = {56'h0, 8'h0f, 8'h00, pkt_count, 8'h01, link_prefix};
    iv = {56'h0, 8'h00, pkt_count, 8'h01, link_prefix, 8'h00};
    tag = link_cipher(link_cipher(nonce) ^ {8'h00, plain});
    ks = link_cipher(iv);
    cipher = plain ^ ks[119:0];
    pk = {cipher, tag[15:0], 8'h00, pkt_count};
    o.accepted = 1'b1;
    o.packet_bytes_0_7 = pk[63:0];
    o.packet_bytes_8_15 = pk[127:64];
    o.packet_bytes_16_19 = pk[159:128];
    return o;
  endfunction

  always @(posedge clk) begin
    pkt_out_t want;
    if (!rst_n) begin
      key_lo <= '0;
      key_hi <= '0;
      link_prefix <= '0;
      vendor_reg <= '0;
      ready <= 1'b0;
      pkt_count <= 16'h0001;
      packet_q.delete();
      mismatches <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_KEY_LO: key_lo <= cfg_data;
          REG_KEY_HI: key_hi <= cfg_data;
          REG_LINK:   link_prefix <= cfg_data[31:0];
          REG_VENDOR: vendor_reg <= cfg_data[15:0];
          REG_COUNT:  pkt_count <= (cfg_data[15:0] == 16'h0) ? 16'h0001 : cfg_data[15:0];
          REG_READY:  ready <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        packet_q.push_back(encrypt_command(in_data));
        if (ready) pkt_count <= (pkt_count == 16'hffff) ? 16'h0001 : pkt_count + 16'h1;
      end
      if (out_pop && !out_empty) begin
        if (packet_q.size() == 0) begin
          $error("packet popped with none outstanding: %h", out_data);
          mismatches <= mismatches + 1;
        end else begin
          want = packet_q.pop_front();
          if (out_data.accepted !== want.accepted)
            $error("accepted: expected %h, got %h", want.accepted, out_data.accepted);
          if (out_data.packet_bytes_0_7 !== want.packet_bytes_0_7)
            $error("packet_bytes_0_7: expected %h, got %h",
                   want.packet_bytes_0_7, out_data.packet_bytes_0_7);
          if (out_data.packet_bytes_8_15 !== want.packet_bytes_8_15)
            $error("packet_bytes_8_15: expected %h, got %h",
                   want.packet_bytes_8_15, out_data.packet_bytes_8_15);
          if (out_data.packet_bytes_16_19 !== want.packet_bytes_16_19)
            $error("packet_bytes_16_19: expected %h, got %h",
                   want.packet_bytes_16_19, out_data.packet_bytes_16_19);
          if (out_data !== want) mismatches <= mismatches + 1;
        end
      end
      pending <= packet_q.size();
    end
  end

endmodule

// ===== verif/mesh_command_packet_encrypt_unit_tb.sv =====
// Top of the mesh command packet encryptor testbench: drives commands,
// register writes and pop stalls, and gives the verdict from the checker.
// Depends on mcpe_pkg, the block and mesh_command_packet_encrypt_checker.
`timescale 1ns / 100ps
module mesh_command_packet_encrypt_unit_tb;
  import mcpe_pkg::*;

  localparam logic [CfgIdxW-1:0] UNUSED_IDX = 3'd7;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  cmd_in_t             in_data;
  logic                out_empty;
  logic                out_pop;
  pkt_out_t            out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int                  mismatches;
  int                  pending;
  int                  cyc;

  mesh_command_packet_encrypt_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  mesh_command_packet_encrypt_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // The receiver cycles through always-pop, random, sparse and mostly-pop modes.
  initial begin
    cyc = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      case ((cyc / 97) % 4)
        0: out_pop = 1'b1;
        1: out_pop = $urandom_range(0, 1);
        2: out_pop = (cyc % 11) == 0;
        default: out_pop = $urandom_range(0, 3) != 0;
      endcase
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Entered and left at a falling edge; push stays high for the next item.
  task automatic push_cmd(input cmd_in_t c);
    in_push = 1'b1;
    in_data = c;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic drain();
    in_push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic cmd_in_t random_cmd();
    cmd_in_t c;
    c.target_addr = 16'($urandom);
    c.command_op = 8'($urandom);
    c.payload_lo = {$urandom, $urandom};
    c.payload_hi = 16'($urandom);
    c.payload_count = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(11, 15))
                                                  : 4'($urandom_range(0, 10));
    return c;
  endfunction

  task automatic random_burst(input int items);
    int sent, run;
    sent = 0;
    while (sent < items) begin
      run = $urandom_range(1, 12);
      for (int i = 0; i < run && sent < items; i++) begin
        push_cmd(random_cmd());
        sent++;
      end
      in_push = 1'b0;
      if ($urandom_range(0, 9) >= 3) repeat ($urandom_range(1, 60)) @(negedge clk);
    end
  endtask

  task automatic directed_cmd(input logic [15:0] addr, input logic [7:0] op,
                              input logic [79:0] body, input logic [3:0] n);
    cmd_in_t c;
    c.target_addr = addr;
    c.command_op = op;
    c.payload_lo = body[63:0];
    c.payload_hi = body[79:64];
    c.payload_count = n;
    push_cmd(c);
  endtask

  initial begin
    logic [15:0] start;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_KEY_LO;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Session not ready after reset: items are refused.
    directed_cmd(16'h1234, 8'h56, {80{1'b1}}, 4'd10);
    directed_cmd(16'hffff, 8'hff, {80{1'b1}}, 4'd15);
    drain();

    // All-zero key and link, count start of zero loads one.
    write_reg(UNUSED_IDX, {64{1'b1}});
    write_reg(REG_COUNT, 64'h0);
    write_reg(REG_READY, 64'h1);
    directed_cmd(16'h0000, 8'h00, 80'h0, 4'd0);
    directed_cmd(16'hffff, 8'hff, {80{1'b1}}, 4'd10);
    directed_cmd(16'hffff, 8'hff, {80{1'b1}}, 4'd11);
    directed_cmd(16'ha5c3, 8'h81, {80{1'b1}}, 4'd15);
    directed_cmd(16'h0001, 8'h7e, 80'h0123456789abcdef0f1e, 4'd8);
    directed_cmd(16'h8000, 8'h01, 80'hffee_ddcc_bbaa_9988_7766, 4'd9);
    directed_cmd(16'h00ff, 8'h80, 80'h5a5a_5a5a_5a5a_5a5a_5a5a, 4'd1);
    drain();

    // All-ones settings and the counter wrap past 0xffff.
    write_reg(REG_KEY_LO, {64{1'b1}});
    write_reg(REG_KEY_HI, {64{1'b1}});
    write_reg(REG_LINK, 64'hffff_ffff);
    write_reg(REG_VENDOR, 64'hffff);
    write_reg(REG_COUNT, 64'hfffe);
    for (int i = 0; i < 4; i++) directed_cmd(16'hffff, 8'h00, {80{1'b1}}, 4'd15);
    directed_cmd(16'h0000, 8'hff, 80'h0, 4'd7);
    drain();

    // Random settings per phase; one phase drops the session midway.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_KEY_LO, {$urandom, $urandom});
      write_reg(REG_KEY_HI, {$urandom, $urandom});
      write_reg(REG_LINK, {32'h0, $urandom});
      write_reg(REG_VENDOR, {48'h0, 16'($urandom)});
      case (ph % 3)
        0: start = 16'(16'hffff - $urandom_range(0, 40));
        1: start = 16'($urandom);
        default: start = 16'h0;
      endcase
      write_reg(REG_COUNT, {48'h0, start});
      random_burst(ph == 2 ? 60 : 140);
      if (ph == 2) begin
        drain();
        write_reg(REG_READY, 64'h0);
        random_burst(40);
        drain();
        write_reg(REG_READY, 64'h1);
        random_burst(60);
      end
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
